### src/chained_hash_set_engine_defines.svh
// Assertion helpers shared by the chained hash set engine.
`ifndef CHAINED_HASH_SET_ENGINE_DEFINES_SVH
`define CHAINED_HASH_SET_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CHSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/chse_pkg.sv
`timescale 1ns / 1ps

package chse_pkg;

    localparam int DEFAULT_BUCKETS    = 64;
    localparam int DEFAULT_POOL_NODES = 256;
    localparam int KEY_W              = 32;

    // Request actions.
    localparam logic [1:0] ACTION_INSERT = 2'd0;
    localparam logic [1:0] ACTION_REMOVE = 2'd1;
    localparam logic [1:0] ACTION_SEARCH = 2'd2;
    localparam logic [1:0] ACTION_CLEAR  = 2'd3;

    // Response status codes.
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] entries;
    } rsp_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_INS,
        S_HEAD,
        S_NODE,
        S_REL,
        S_FIN
    } state_t;

endpackage

### src/chse_ram.sv
`timescale 1ns / 1ps

module chse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/chse_hash.sv
`timescale 1ns / 1ps

module chse_hash #(
    parameter int BUCKETS = chse_pkg::DEFAULT_BUCKETS,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [chse_pkg::KEY_W-1:0] key,
    output logic                              done,
    output logic [BW-1:0]                     bucket
);

    localparam logic [31:0] BMASK   = 32'(BUCKETS - 1);
    localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            logic          done_reg;
            logic [BW-1:0] bucket_reg;

            // A power-of-two modulus is a mask on the two's complement key.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bucket_reg <= BW'(key & BMASK);
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end
        else
        begin : g_recip
            // Quotient of the magnitude by multiplication with the rounded-up
            // reciprocal 2^SH / BUCKETS, which is exact for every 32-bit value.
            localparam int L  = $clog2(BUCKETS);
            localparam int SH = 32 + L;
            localparam int MW = 34;
            localparam int RW = L + 1;
            localparam longint unsigned MV =
                ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
            localparam logic [MW-1:0] MC   = MW'(MV);
            localparam logic [31:0]   BV32 = 32'(BUCKETS);
            localparam logic [RW-1:0] BVAL = RW'(BUCKETS);

            logic          v0_reg;
            logic          v1_reg;
            logic          v2_reg;
            logic          done_reg;
            logic [31:0]   mag_reg;
            logic          neg_reg;
            logic [65:0]   prod_reg;
            logic [RW-1:0] rem_reg;
            logic [BW-1:0] bucket_reg;
            logic [31:0]   quot;
            logic [31:0]   back;

            // Stage valid bits.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v0_reg   <= 1'b0;
                    v1_reg   <= 1'b0;
                    v2_reg   <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    v0_reg   <= start;
                    v1_reg   <= v0_reg;
                    v2_reg   <= v1_reg;
                    done_reg <= v2_reg;
                end
            end

            assign quot = 32'(prod_reg >> SH);
            assign back = quot * BV32;

            // Magnitude, reciprocal product, remainder, then a fold into the
            // non-negative range for negative keys.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    neg_reg <= key[31];
                    mag_reg <= key[31] ? (32'd0 - 32'(key)) : 32'(key);
                end
                prod_reg <= 66'(mag_reg) * 66'(MC);
                if (v1_reg)
                begin
                    rem_reg <= RW'(mag_reg - back);
                end
                if (v2_reg)
                begin
                    bucket_reg <= (neg_reg && (rem_reg != '0)) ? BW'(BVAL - rem_reg)
                                                               : BW'(rem_reg);
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end
    endgenerate

endmodule

### src/chained_hash_set_engine.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  chse_pkg::req_t  (action, key)
// rsp      out        rsp_valid / rsp_ready  chse_pkg::rsp_t  (status, entries)
//
// Insert steps through accept, hash, head write and finish. Remove and search go
// through accept, hash and head read, then the chain node by node, then finish; a
// remove that hits also frees its node. A bucket count that is not a power of two
// sends the hash through the remainder pipeline. After reset and for every clear,
// a sweep rebuilds bucket heads and the free list; no request is taken meanwhile.
// The finish step waits while an earlier response is still held in its register.

module chained_hash_set_engine #(
    parameter int BUCKETS    = chse_pkg::DEFAULT_BUCKETS,
    parameter int POOL_NODES = chse_pkg::DEFAULT_POOL_NODES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  chse_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output chse_pkg::rsp_t rsp
);

    `include "chained_hash_set_engine_defines.svh"

    localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int IW      = $clog2(POOL_NODES + 1);
    localparam int KW      = chse_pkg::KEY_W;
    localparam int NW      = KW + IW;
    localparam int SWEEP_N = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
    localparam int SW      = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;
    localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

    chse_pkg::state_t state_reg, state_next;
    logic              init_reg, init_next;
    logic [1:0]        act_reg, act_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [BW-1:0]     bucket_reg, bucket_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     prev_reg, prev_next;
    logic [KW-1:0]     prev_key_reg, prev_key_next;
    logic [IW-1:0]     steps_reg, steps_next;
    logic [IW-1:0]     free_head_reg, free_head_next;
    logic [IW-1:0]     count_reg, count_next;
    logic [SW-1:0]     sweep_reg, sweep_next;
    logic [1:0]        status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    chse_pkg::rsp_t    rsp_reg, rsp_next;

    logic              head_we;
    logic [BW-1:0]     head_waddr, head_raddr;
    logic [IW-1:0]     head_wdata, head_rdata;
    logic              node_we;
    logic [AW-1:0]     node_waddr, node_raddr;
    logic [NW-1:0]     node_wdata, node_rdata;
    logic [KW-1:0]     node_key;
    logic [IW-1:0]     node_link;
    logic [IW-1:0]     steps_inc;

    logic              hash_start;
    logic              hash_done;
    logic [BW-1:0]     hash_bucket;

    chse_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    chse_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    chse_hash #(.BUCKETS(BUCKETS)) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (req.key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    assign node_key  = node_rdata[NW-1:IW];
    assign node_link = node_rdata[IW-1:0];
    assign steps_inc = steps_reg + 1'b1;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chse_pkg::S_SWEEP;
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            sweep_reg     <= sweep_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        bucket_reg   <= bucket_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_key_reg <= prev_key_next;
        steps_reg    <= steps_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    // Sequencer: hash, read head, walk the chain, write back.
    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        bucket_next    = bucket_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_key_next  = prev_key_reg;
        steps_next     = steps_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        sweep_next     = sweep_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        head_we        = 1'b0;
        head_waddr     = bucket_reg;
        head_wdata     = NIL;
        head_raddr     = bucket_reg;
        node_we        = 1'b0;
        node_waddr     = cur_reg[AW-1:0];
        node_wdata     = {key_reg, free_head_reg};
        node_raddr     = cur_reg[AW-1:0];
        hash_start     = 1'b0;

        case (state_reg)
            chse_pkg::S_SWEEP:
            begin
                // Empty one bucket and thread one pool node per cycle.
                head_we    = (32'(sweep_reg) < BUCKETS);
                head_waddr = BW'(sweep_reg);
                head_wdata = NIL;
                node_we    = (32'(sweep_reg) < POOL_NODES);
                node_waddr = AW'(sweep_reg);
                node_wdata = {{KW{1'b0}}, IW'(sweep_reg) + 1'b1};
                if (sweep_reg == SW'(SWEEP_N - 1))
                begin
                    free_head_next = '0;
                    count_next     = '0;
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = chse_pkg::S_IDLE;
                    end
                    else
                    begin
                        status_next = chse_pkg::STATUS_DONE;
                        state_next  = chse_pkg::S_FIN;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            chse_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = req.action;
                    key_next = req.key;
                    if (req.action == chse_pkg::ACTION_CLEAR)
                    begin
                        sweep_next = '0;
                        state_next = chse_pkg::S_SWEEP;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = chse_pkg::S_HASH;
                    end
                end
            end

            chse_pkg::S_HASH:
            begin
                head_raddr = hash_bucket;
                node_raddr = free_head_reg[AW-1:0];
                if (hash_done)
                begin
                    bucket_next = hash_bucket;
                    if (act_reg == chse_pkg::ACTION_INSERT)
                    begin
                        if (free_head_reg == NIL)
                        begin
                            status_next = chse_pkg::STATUS_FULL;
                            state_next  = chse_pkg::S_FIN;
                        end
                        else
                        begin
                            state_next = chse_pkg::S_INS;
                        end
                    end
                    else
                    begin
                        state_next = chse_pkg::S_HEAD;
                    end
                end
            end

            chse_pkg::S_INS:
            begin
                // Prepend the free node to the chain.
                head_we        = 1'b1;
                head_wdata     = free_head_reg;
                node_we        = 1'b1;
                node_waddr     = free_head_reg[AW-1:0];
                node_wdata     = {key_reg, head_rdata};
                free_head_next = node_link;
                count_next     = count_reg + 1'b1;
                status_next    = chse_pkg::STATUS_DONE;
                state_next     = chse_pkg::S_FIN;
            end

            chse_pkg::S_HEAD:
            begin
                if (head_rdata >= NIL)
                begin
                    status_next = chse_pkg::STATUS_MISSING;
                    state_next  = chse_pkg::S_FIN;
                end
                else
                begin
                    cur_next   = head_rdata;
                    prev_next  = NIL;
                    steps_next = '0;
                    node_raddr = head_rdata[AW-1:0];
                    state_next = chse_pkg::S_NODE;
                end
            end

            chse_pkg::S_NODE:
            begin
                if (node_key == key_reg)
                begin
                    status_next = chse_pkg::STATUS_DONE;
                    if (act_reg == chse_pkg::ACTION_REMOVE)
                    begin
                        // Unlink from the bucket head or from the previous node.
                        if (prev_reg == NIL)
                        begin
                            head_we    = 1'b1;
                            head_wdata = node_link;
                        end
                        else
                        begin
                            node_we    = 1'b1;
                            node_waddr = prev_reg[AW-1:0];
                            node_wdata = {prev_key_reg, node_link};
                        end
                        state_next = chse_pkg::S_REL;
                    end
                    else
                    begin
                        state_next = chse_pkg::S_FIN;
                    end
                end
                else if ((node_link >= NIL) || (steps_inc == NIL))
                begin
                    status_next = chse_pkg::STATUS_MISSING;
                    state_next  = chse_pkg::S_FIN;
                end
                else
                begin
                    prev_next     = cur_reg;
                    prev_key_next = node_key;
                    cur_next      = node_link;
                    steps_next    = steps_inc;
                    node_raddr    = node_link[AW-1:0];
                end
            end

            chse_pkg::S_REL:
            begin
                // Return the unlinked node to the free list.
                node_we        = 1'b1;
                node_waddr     = cur_reg[AW-1:0];
                node_wdata     = {key_reg, free_head_reg};
                free_head_next = cur_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = chse_pkg::S_FIN;
            end

            chse_pkg::S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = status_reg;
                    rsp_next.entries = 9'(count_reg);
                    state_next       = chse_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = chse_pkg::S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == chse_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The free list is empty exactly when every node holds a key.
    `CHSE_ASSERT_NOW(a_pool_balance, 1'b1,
        ((free_head_reg == NIL) == (count_reg == NIL)),
        "free list and entry count disagree")
    // An accepted request closes the request channel until it is answered.
    `CHSE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready,
        "request channel open while a request is in work")
    // Finishing loads the response register and reopens the request channel.
    `CHSE_ASSERT_NEXT(a_finish_loads,
        (state_reg == chse_pkg::S_FIN) && (!rsp_valid_reg || rsp_ready),
        rsp_valid && req_ready,
        "finished request produced no response")
    // The entry count never goes past the pool size.
    `CHSE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= NIL,
        "entry count beyond pool size")

endmodule

### sim/chse_checker.sv
`timescale 1ns / 1ps

module chse_checker #(
    parameter int BUCKETS    = chse_pkg::DEFAULT_BUCKETS,
    parameter int POOL_NODES = chse_pkg::DEFAULT_POOL_NODES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  chse_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  chse_pkg::rsp_t rsp,
    output int             fail_count,
    output int             pending
);

    // Shadow copy of the table.
    int unsigned     head_of[BUCKETS];
    logic [31:0]     key_of[POOL_NODES];
    int unsigned     link_of[POOL_NODES];
    int unsigned     free_node;
    int unsigned     stored;
    chse_pkg::rsp_t  expected_rsp[$];

    function automatic int unsigned bucket_for(logic signed [31:0] k);
        longint r;
        r = longint'(k) % BUCKETS;
        if (r < 0)
            r += BUCKETS;
        return int'(r);
    endfunction

    function automatic void rebuild_table();
        for (int i = 0; i < BUCKETS; i++)
            head_of[i] = POOL_NODES;
        for (int i = 0; i < POOL_NODES; i++)
            link_of[i] = i + 1;
        free_node = 0;
        stored = 0;
    endfunction

    // Apply one request to the shadow table and return the expected response.
    function automatic chse_pkg::rsp_t apply_request(chse_pkg::req_t r);
        chse_pkg::rsp_t o;
        int unsigned    b;
        int unsigned    cur;
        int unsigned    prev;
        int unsigned    n;
        b = bucket_for(r.key);
        o.status = chse_pkg::STATUS_DONE;
        if (r.action == chse_pkg::ACTION_INSERT)
        begin
            if (free_node >= POOL_NODES)
                o.status = chse_pkg::STATUS_FULL;
            else
            begin
                n = free_node;
                free_node = link_of[n];
                key_of[n] = r.key;
                link_of[n] = head_of[b];
                head_of[b] = n;
                stored++;
            end
        end
        else if (r.action == chse_pkg::ACTION_REMOVE || r.action == chse_pkg::ACTION_SEARCH)
        begin
            o.status = chse_pkg::STATUS_MISSING;
            prev = POOL_NODES;
            cur = head_of[b];
            for (int s = 0; cur < POOL_NODES && s < POOL_NODES; s++)
            begin
                if (key_of[cur] == r.key)
                begin
                    o.status = chse_pkg::STATUS_DONE;
                    if (r.action == chse_pkg::ACTION_REMOVE)
                    begin
                        if (prev >= POOL_NODES)
                            head_of[b] = link_of[cur];
                        else
                            link_of[prev] = link_of[cur];
                        link_of[cur] = free_node;
                        free_node = cur;
                        if (stored > 0)
                            stored--;
                    end
                    break;
                end
                prev = cur;
                cur = link_of[cur];
            end
        end
        else
            rebuild_table();
        o.entries = stored[8:0];
        return o;
    endfunction

    initial
    begin
        rebuild_table();
        fail_count = 0;
        pending = 0;
    end

    // Predict on each accepted request, compare on each accepted response.
    always @(posedge clk)
    begin
        chse_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected response status=%0d entries=%0d",
                       rsp.status, rsp.entries);
                fail_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.entries !== want.entries)
                begin
                    $error("entries expected %0d actual %0d",
                           want.entries, rsp.entries);
                    fail_count++;
                end
            end
        end
        if (rst_n && req_valid && req_ready)
            expected_rsp.push_back(apply_request(req));
        pending = expected_rsp.size();
    end

endmodule

### sim/tb_chained_hash_set_engine.sv
`timescale 1ns / 1ps

module tb_chained_hash_set_engine;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int STALL_LIMIT     = 20000;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    chse_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    chse_pkg::rsp_t rsp;
    int             fail_count;
    int             pending;
    int             idle_cycles;
    logic [31:0]    used_keys[$];

    chained_hash_set_engine dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    chse_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Send one request and hold it until it is taken.
    task automatic send_request(logic [1:0] act, logic [31:0] k);
        req_valid <= 1'b1;
        req.action <= act;
        req.key <= k;
        used_keys.push_back(k);
        if (used_keys.size() > 40)
            void'(used_keys.pop_front());
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        req_valid <= 1'b0;
    endtask

    // Mostly keys seen recently or near-colliding ones, so chains grow and hits occur.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        else if (sel < 8)
            return 32'($urandom_range(0, 7) * 64 - 256 + $urandom_range(0, 3));
        return $urandom;
    endfunction

    // Receiver stalls in runs of its own pattern.
    initial
    begin
        int mode;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 30))
            begin
                if (mode == 0)
                    rsp_ready <= 1'b1;
                else if (mode == 1)
                    rsp_ready <= 1'b0;
                else
                    rsp_ready <= ($urandom_range(0, 3) != 0);
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no handshake.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int burst;
        int act;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-table misses, extreme keys, duplicates, clear.
        send_request(chse_pkg::ACTION_SEARCH, 32'h0000_0000);
        send_request(chse_pkg::ACTION_REMOVE, 32'h8000_0000);
        send_request(chse_pkg::ACTION_INSERT, 32'h8000_0000);
        send_request(chse_pkg::ACTION_INSERT, 32'h7FFF_FFFF);
        send_request(chse_pkg::ACTION_INSERT, 32'hFFFF_FFFF);
        send_request(chse_pkg::ACTION_INSERT, 32'h0000_0000);
        send_request(chse_pkg::ACTION_INSERT, 32'hFFFF_FFFF);
        send_request(chse_pkg::ACTION_INSERT, 32'h0000_0040);
        send_request(chse_pkg::ACTION_SEARCH, 32'hFFFF_FFFF);
        send_request(chse_pkg::ACTION_REMOVE, 32'hFFFF_FFFF);
        send_request(chse_pkg::ACTION_SEARCH, 32'hFFFF_FFFF);
        send_request(chse_pkg::ACTION_REMOVE, 32'hFFFF_FFFF);
        send_request(chse_pkg::ACTION_REMOVE, 32'hFFFF_FFFF);
        send_request(chse_pkg::ACTION_REMOVE, 32'h0000_0000);
        send_request(chse_pkg::ACTION_SEARCH, 32'h0000_0040);
        send_request(chse_pkg::ACTION_SEARCH, 32'h7FFF_FFFF);
        send_request(chse_pkg::ACTION_CLEAR, 32'h5555_AAAA);
        send_request(chse_pkg::ACTION_SEARCH, 32'h7FFF_FFFF);

        // Fill the pool past capacity so full and the top of entries are hit.
        for (int i = 0; i < 258; i++)
            send_request(chse_pkg::ACTION_INSERT, (i % 2) ? $urandom : 32'(i * 64 + 5));
        for (int i = 0; i < 20; i++)
            send_request(chse_pkg::ACTION_REMOVE, 32'(i * 128 + 5));
        send_request(chse_pkg::ACTION_SEARCH, 32'(64 + 5));
        send_request(chse_pkg::ACTION_CLEAR, 32'hAAAA_5555);
        drop_valid();

        // Random bursts with gaps; clears kept rare so the table fills up.
        for (int n = 0; n < RANDOM_REQUESTS; n += burst)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++)
            begin
                act = $urandom_range(0, 99);
                if (act < 45)
                    send_request(chse_pkg::ACTION_INSERT, pick_key());
                else if (act < 70)
                    send_request(chse_pkg::ACTION_REMOVE, pick_key());
                else if (act < 99)
                    send_request(chse_pkg::ACTION_SEARCH, pick_key());
                else
                    send_request(chse_pkg::ACTION_CLEAR, $urandom);
            end
            drop_valid();
            repeat ($urandom_range(0, 12)) @(posedge clk);
        end
        drop_valid();

        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### chained_hash_set_engine.f
+incdir+src
src/chse_pkg.sv
src/chse_ram.sv
src/chse_hash.sv
src/chained_hash_set_engine.sv
sim/chse_checker.sv
sim/tb_chained_hash_set_engine.sv
